[design/pwefs_pkg.sv]
package pwefs_pkg;

    // register indexes of the configuration port
    localparam logic CFG_CONTROL = 1'b0;
    localparam logic CFG_COLORS  = 1'b1;

    // control register bits
    localparam int CTL_EXPAND_BIT = 3;
    localparam int CTL_OR_BIT     = 4;
    localparam int CTL_XOR_BIT    = 5;
    localparam int CTL_FLIP_BIT   = 6;

    localparam logic OPC_WRITE  = 1'b0;
    localparam logic OPC_STATUS = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    // collision flag per pixel position (pixel 3 in bits 1:0)
    localparam logic [7:0] COLL_PIX3 = 8'h88;
    localparam logic [7:0] COLL_PIX2 = 8'h44;
    localparam logic [7:0] COLL_PIX1 = 8'h22;
    localparam logic [7:0] COLL_PIX0 = 8'h11;
    localparam logic [7:0] COLL_KEEP = 8'h0F;

    typedef enum logic {
        KIND_WRITE,
        KIND_STATUS
    } t_kind;

    typedef struct packed {
        logic [1:0] shift;
        logic       expand;
        logic       merge_or;
        logic       merge_xor;
        logic       flip;
    } t_ctl;

    typedef struct packed {
        t_kind       kind;
        logic [13:0] offset;
        logic [7:0]  data;
        logic [7:0]  old;
    } t_item;

    function automatic logic [7:0] reverse_pixels(input logic [7:0] v);
        return {v[1:0], v[3:2], v[5:4], v[7:6]};
    endfunction

endpackage

[design/pwefs_front.sv]
module pwefs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pwefs_pkg::t_ctl  i_ctl,
    input  logic [3:0]       i_colors,
    input  logic             i_ctl_write,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_opcode,
    input  logic [13:0]      i_write_offset,
    input  logic [7:0]       i_write_value,
    input  logic [7:0]       i_old_byte,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output pwefs_pkg::t_item o_push_item
);

    logic       r_toggle;
    logic       n_toggle;
    logic [3:0] nib;
    logic [1:0] c0;
    logic [1:0] c1;
    logic [7:0] expanded;
    logic [7:0] pre_flip;
    logic       accept;
    logic       is_write;

    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;
    assign accept       = i_in_valid && i_push_ready;
    assign is_write     = (i_opcode == pwefs_pkg::OPC_WRITE);

    assign nib = r_toggle ? i_write_value[3:0] : i_write_value[7:4];
    assign c0  = i_colors[1:0];
    assign c1  = i_colors[3:2];

    // nibble bit 3 becomes pixel 0 (bits 7:6)
    assign expanded = {nib[3] ? c1 : c0, nib[2] ? c1 : c0,
                       nib[1] ? c1 : c0, nib[0] ? c1 : c0};
    assign pre_flip = i_ctl.expand ? expanded : i_write_value;

    always_comb begin
        o_push_item.kind   = is_write ? pwefs_pkg::KIND_WRITE : pwefs_pkg::KIND_STATUS;
        o_push_item.offset = i_write_offset;
        o_push_item.data   = i_ctl.flip ? pwefs_pkg::reverse_pixels(pre_flip) : pre_flip;
        o_push_item.old    = i_old_byte;
    end

    always_comb begin
        n_toggle = r_toggle;
        if (i_ctl_write) begin
            n_toggle = 1'b0;
        end else if (accept && is_write && i_ctl.expand) begin
            n_toggle = ~r_toggle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle <= 1'b0;
        end else begin
            r_toggle <= n_toggle;
        end
    end

endmodule

[design/pwefs_queue.sv]
module pwefs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  pwefs_pkg::t_item i_push_item,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output pwefs_pkg::t_item o_pop_item
);

    localparam int QDEPTH = pwefs_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    pwefs_pkg::t_item r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_pop_moves_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_rd_ptr != $past(r_rd_ptr) || QDEPTH == 1)
        else $error("pop did not advance read pointer");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(QDEPTH)) && !pop |=> r_count == CNT_W'(QDEPTH))
        else $error("full queue lost an entry");

endmodule

[design/pwefs_back.sv]
module pwefs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pwefs_pkg::t_ctl  i_ctl,
    input  logic             i_ctl_write,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  pwefs_pkg::t_item i_pop_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_store_enable,
    output logic [13:0]      o_store_offset,
    output logic [7:0]       o_store_byte,
    output logic [7:0]       o_status_byte
);

    logic        r_out_valid;
    logic        r_store_enable;
    logic [13:0] r_store_offset;
    logic [7:0]  r_store_byte;
    logic [7:0]  r_status_byte;
    logic [7:0]  r_carry;
    logic [7:0]  r_flags;
    logic [7:0]  n_carry;
    logic [7:0]  n_flags;

    logic        pop;
    logic        is_write;
    logic [3:0]  bits;
    logic [15:0] wide;
    logic [7:0]  shifted;
    logic [7:0]  spill;
    logic [7:0]  merged;
    logic [7:0]  old;
    logic [7:0]  hits;
    logic [7:0]  final_byte;

    assign o_pop_ready = !r_out_valid || i_out_ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign is_write    = (i_pop_item.kind == pwefs_pkg::KIND_WRITE);
    assign old         = i_pop_item.old;
    assign bits        = {1'b0, i_ctl.shift, 1'b0};

    // flipped data moves toward the high end, spill lands low in the carry
    always_comb begin
        if (i_ctl.flip) begin
            wide    = {8'h00, i_pop_item.data} << bits;
            shifted = wide[7:0];
            spill   = wide[15:8];
        end else begin
            wide    = {i_pop_item.data, 8'h00} >> bits;
            shifted = wide[15:8];
            spill   = wide[7:0];
        end
    end

    assign merged = shifted | r_carry;

    assign hits = (((merged[1:0] != 2'b00) && (old[1:0] != 2'b00)) ? pwefs_pkg::COLL_PIX3 : 8'h00)
                | (((merged[3:2] != 2'b00) && (old[3:2] != 2'b00)) ? pwefs_pkg::COLL_PIX2 : 8'h00)
                | (((merged[5:4] != 2'b00) && (old[5:4] != 2'b00)) ? pwefs_pkg::COLL_PIX1 : 8'h00)
                | (((merged[7:6] != 2'b00) && (old[7:6] != 2'b00)) ? pwefs_pkg::COLL_PIX0 : 8'h00);

    always_comb begin
        if (i_ctl.merge_xor) begin
            final_byte = merged ^ old;
        end else if (i_ctl.merge_or) begin
            final_byte = merged | old;
        end else begin
            final_byte = merged;
        end
    end

    always_comb begin
        n_carry = r_carry;
        n_flags = r_flags;
        if (pop) begin
            if (is_write) begin
                n_carry = spill;
                if (i_ctl.merge_or || i_ctl.merge_xor) begin
                    n_flags = (r_flags & pwefs_pkg::COLL_KEEP) | hits;
                end
            end else begin
                n_flags = 8'h00;
            end
        end
        if (i_ctl_write) begin
            n_carry = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_carry     <= 8'h00;
            r_flags     <= 8'h00;
        end else begin
            r_carry <= n_carry;
            r_flags <= n_flags;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_store_enable <= is_write;
            r_store_offset <= is_write ? i_pop_item.offset : 14'd0;
            r_store_byte   <= is_write ? final_byte : 8'h00;
            r_status_byte  <= is_write ? 8'h00 : r_flags;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_store_enable = r_store_enable;
    assign o_store_offset = r_store_offset;
    assign o_store_byte   = r_store_byte;
    assign o_status_byte  = r_status_byte;

endmodule

[design/pixel_write_expand_flip_shift.sv]
// A transaction accepted at the input is written into the two-entry queue; the output register
// loads it from the queue when the back end pops it, which waits while the output is stalled.
// Throughput: one transaction per cycle; the queue and output register let each side stall.
// Reset (synchronous, active low) clears the control and color registers, the nibble
// toggle, the shift carry, the collision flags, the queue and the output valid.
module pixel_write_expand_flip_shift (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [13:0] i_write_offset,
    input  logic [7:0]  i_write_value,
    input  logic [7:0]  i_old_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_store_enable,
    output logic [13:0] o_store_offset,
    output logic [7:0]  o_store_byte,
    output logic [7:0]  o_status_byte
);

    logic [7:0]       r_control;
    logic [3:0]       r_colors;
    logic             ctl_write;
    pwefs_pkg::t_ctl  ctl;
    logic             push_valid;
    logic             push_ready;
    pwefs_pkg::t_item push_item;
    logic             pop_valid;
    logic             pop_ready;
    pwefs_pkg::t_item pop_item;

    assign ctl_write = i_cfg_we && (i_cfg_index == pwefs_pkg::CFG_CONTROL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= 8'h00;
            r_colors  <= 4'h0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pwefs_pkg::CFG_CONTROL: r_control <= i_cfg_data;
                pwefs_pkg::CFG_COLORS:  r_colors  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ctl.shift     = r_control[1:0];
        ctl.expand    = r_control[pwefs_pkg::CTL_EXPAND_BIT];
        ctl.merge_or  = r_control[pwefs_pkg::CTL_OR_BIT];
        ctl.merge_xor = r_control[pwefs_pkg::CTL_XOR_BIT];
        ctl.flip      = r_control[pwefs_pkg::CTL_FLIP_BIT];
    end

    pwefs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_colors       (r_colors),
        .i_ctl_write    (ctl_write),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_write_offset (i_write_offset),
        .i_write_value  (i_write_value),
        .i_old_byte     (i_old_byte),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_item    (push_item)
    );

    pwefs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    pwefs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_ctl_write    (ctl_write),
        .i_pop_valid    (pop_valid),
        .o_pop_ready    (pop_ready),
        .i_pop_item     (pop_item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_store_enable (o_store_enable),
        .o_store_offset (o_store_offset),
        .o_store_byte   (o_store_byte),
        .o_status_byte  (o_status_byte)
    );

    a_write_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_store_enable |-> o_status_byte == 8'h00)
        else $error("write result carries status");

    a_status_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_store_enable |-> o_store_offset == 14'd0 && o_store_byte == 8'h00)
        else $error("status result carries store data");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

[test/tb_pixel_write_expand_flip_shift.sv]
module tb_pixel_write_expand_flip_shift;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 1600;

    typedef struct {
        logic        op;
        logic [13:0] ofs;
        logic [7:0]  value;
        logic [7:0]  old;
    } t_pixel_req;

    typedef struct {
        logic        en;
        logic [13:0] ofs;
        logic [7:0]  data;
        logic [7:0]  status;
    } t_store_rec;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = pwefs_pkg::CFG_CONTROL;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_opcode = pwefs_pkg::OPC_WRITE;
    logic [13:0] i_write_offset = 14'h0000;
    logic [7:0]  i_write_value = 8'h00;
    logic [7:0]  i_old_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_store_enable;
    logic [13:0] o_store_offset;
    logic [7:0]  o_store_byte;
    logic [7:0]  o_status_byte;

    pixel_write_expand_flip_shift uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_write_offset (i_write_offset),
        .i_write_value  (i_write_value),
        .i_old_byte     (i_old_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_store_enable (o_store_enable),
        .o_store_offset (o_store_offset),
        .o_store_byte   (o_store_byte),
        .o_status_byte  (o_status_byte)
    );

    // model state
    logic [7:0] m_ctl = 8'h00;
    logic [3:0] m_colors = 4'h0;
    logic       m_low_nibble = 1'b0;
    logic [7:0] m_carry = 8'h00;
    logic [7:0] m_coll = 8'h00;

    t_pixel_req req_q[$];
    t_store_rec store_expected_q[$];

    t_pixel_req cur_req;
    logic       in_present;
    int         in_gap = 0;
    bit         in_steady = 1'b0;
    int         out_stall = 0;
    bit         out_steady = 1'b0;
    int         fail_count = 0;
    int         cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_store_rec predict_store(input t_pixel_req req);
        t_store_rec  r;
        logic [7:0]  px;
        logic [7:0]  mirrored;
        logic [3:0]  nib;
        logic [15:0] wide;
        int          sh;
        r.en = 1'b0;
        r.ofs = '0;
        r.data = '0;
        r.status = '0;
        if (req.op == pwefs_pkg::OPC_STATUS) begin
            r.status = m_coll;
            m_coll = 8'h00;
            return r;
        end
        px = req.value;
        if (m_ctl[pwefs_pkg::CTL_EXPAND_BIT]) begin
            nib = m_low_nibble ? req.value[3:0] : req.value[7:4];
            // nibble bit 3 lands in pixel 0 (bits 7:6)
            for (int k = 0; k < 4; k++)
                px[2*k +: 2] = nib[k] ? m_colors[3:2] : m_colors[1:0];
            m_low_nibble = ~m_low_nibble;
        end
        sh = m_ctl[1:0];
        if (m_ctl[pwefs_pkg::CTL_FLIP_BIT]) begin
            for (int k = 0; k < 4; k++)
                mirrored[2*k +: 2] = px[6-2*k +: 2];
            wide = {8'h00, mirrored} << (2 * sh);
            px = wide[7:0] | m_carry;
            m_carry = wide[15:8];
        end else begin
            wide = {px, 8'h00} >> (2 * sh);
            px = wide[15:8] | m_carry;
            m_carry = wide[7:0];
        end
        if (m_ctl[pwefs_pkg::CTL_OR_BIT] || m_ctl[pwefs_pkg::CTL_XOR_BIT]) begin
            m_coll &= pwefs_pkg::COLL_KEEP;
            if (px[1:0] != 0 && req.old[1:0] != 0) m_coll |= pwefs_pkg::COLL_PIX3;
            if (px[3:2] != 0 && req.old[3:2] != 0) m_coll |= pwefs_pkg::COLL_PIX2;
            if (px[5:4] != 0 && req.old[5:4] != 0) m_coll |= pwefs_pkg::COLL_PIX1;
            if (px[7:6] != 0 && req.old[7:6] != 0) m_coll |= pwefs_pkg::COLL_PIX0;
        end
        if (m_ctl[pwefs_pkg::CTL_XOR_BIT]) px ^= req.old;
        else if (m_ctl[pwefs_pkg::CTL_OR_BIT]) px |= req.old;
        r.en = 1'b1;
        r.ofs = req.ofs;
        r.data = px;
        return r;
    endfunction

    task automatic queue_req(input logic op, input logic [13:0] ofs,
                             input logic [7:0] value, input logic [7:0] old);
        t_pixel_req r;
        r.op = op;
        r.ofs = ofs;
        r.value = value;
        r.old = old;
        req_q.push_back(r);
    endtask

    // call right after a rising edge, with nothing in flight
    task automatic program_regs(input logic [7:0] ctl, input bit set_colors,
                                input logic [7:0] colors);
        i_cfg_we <= 1'b1;
        i_cfg_index <= pwefs_pkg::CFG_CONTROL;
        i_cfg_data <= ctl;
        @(posedge i_clk);
        m_ctl = ctl;
        m_low_nibble = 1'b0;
        m_carry = 8'h00;
        if (set_colors) begin
            i_cfg_index <= pwefs_pkg::CFG_COLORS;
            i_cfg_data <= colors;
            @(posedge i_clk);
            m_colors = colors[3:0];
        end
        i_cfg_we <= 1'b0;
    endtask

    // checked at the falling edge, once the rising-edge updates have settled
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (req_q.size() != 0 || i_in_valid || store_expected_q.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // driver: one transaction presented at a time, random gap before each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            in_present = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                store_expected_q.push_back(predict_store(cur_req));
                in_present = 1'b0;
            end
            if (!in_present) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (req_q.size() > 0) begin
                    cur_req = req_q.pop_front();
                    i_opcode <= cur_req.op;
                    i_write_offset <= cur_req.ofs;
                    i_write_value <= cur_req.value;
                    i_old_byte <= cur_req.old;
                    in_present = 1'b1;
                    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
                    in_gap = in_steady ? 0 : $urandom_range(0, 7);
                end
            end
            i_in_valid <= in_present;
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_store_rec want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (store_expected_q.size() == 0) begin
                    $error("unexpected result transaction");
                    fail_count++;
                end else begin
                    want = store_expected_q.pop_front();
                    if (o_store_enable !== want.en) begin
                        $error("store_enable: expected %0h, got %0h", want.en, o_store_enable);
                        fail_count++;
                    end
                    if (o_store_offset !== want.ofs) begin
                        $error("store_offset: expected %h, got %h", want.ofs, o_store_offset);
                        fail_count++;
                    end
                    if (o_store_byte !== want.data) begin
                        $error("store_byte: expected %h, got %h", want.data, o_store_byte);
                        fail_count++;
                    end
                    if (o_status_byte !== want.status) begin
                        $error("status_byte: expected %h, got %h", want.status, o_status_byte);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
                out_stall = out_steady ? 0 : $urandom_range(0, 7);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        int random_items;
        logic [7:0] ctl_val;
        random_items = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: plain, no shift
        queue_req(pwefs_pkg::OPC_WRITE, 14'h3FFF, 8'hFF, 8'hAA);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h0000, 8'h00, 8'hFF);
        queue_req(pwefs_pkg::OPC_STATUS, 14'h3FFF, 8'hFF, 8'hFF);
        wait_idle();

        // OR, shift 3: carried pixels collide on the next write
        program_regs(8'h13, 1'b1, 8'hF5);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h1234, 8'hC3, 8'h00);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h0001, 8'h00, 8'hFF);
        queue_req(pwefs_pkg::OPC_STATUS, 14'h0000, 8'h00, 8'h00);
        queue_req(pwefs_pkg::OPC_STATUS, 14'h0000, 8'h00, 8'h00);
        wait_idle();

        // every control bit set: XOR over OR, expand high then low nibble, flip
        program_regs(8'hFF, 1'b1, 8'h0E);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h2000, 8'hA5, 8'h55);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h3FFE, 8'hA5, 8'hFF);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h0100, 8'h0F, 8'h00);
        wait_idle();

        // plain flip+expand with shift 0: flags must survive until the read
        program_regs(8'h48, 1'b0, 8'h00);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h0ABC, 8'hF0, 8'h33);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h1555, 8'h0F, 8'hCC);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h2AAA, 8'h5A, 8'h00);
        queue_req(pwefs_pkg::OPC_STATUS, 14'h3FFF, 8'h00, 8'h00);
        wait_idle();

        program_regs(8'h21, 1'b1, 8'h00);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h2AAA, 8'hFF, 8'hFF);
        queue_req(pwefs_pkg::OPC_WRITE, 14'h0000, 8'h81, 8'h0F);
        queue_req(pwefs_pkg::OPC_STATUS, 14'h1555, 8'h00, 8'h00);
        wait_idle();

        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: ctl_val = 8'h00;
                1: ctl_val = 8'hFF;
                default: ctl_val = 8'($urandom_range(0, 255));
            endcase
            program_regs(ctl_val, $urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)));
            n = $urandom_range(10, 120);
            repeat (n) begin
                queue_req(($urandom_range(0, 7) == 0) ? pwefs_pkg::OPC_STATUS
                                                      : pwefs_pkg::OPC_WRITE,
                          14'($urandom_range(0, 16383)), pick_byte(), pick_byte());
            end
            random_items += n;
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && store_expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
